### rtl/core/sedge_pkg.sv
// ----------------------------------------------------------------------------
// sedge_pkg
// Shared widths, reset values and types of the Sobel edge threshold core.
// ----------------------------------------------------------------------------
package sedge_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIXEL_W    = 8;
    localparam int SIZE_W     = 12;
    localparam int EDGE_W     = 11;
    localparam int COL_OUT_W  = 11;
    localparam int ROW_W      = 12;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 21;
    localparam int MAG_W      = 22;
    localparam int LIM_W      = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int OUT_DATA_W = 32;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [EDGE_W-1:0] EDGE_LEVEL_RST   = 11'd80;

    localparam logic [PIXEL_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIXEL_W-1:0] EDGE_OFF = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_EDGE_LEVEL   = 2'd2
    } sedge_reg_t;

    typedef logic signed [GRAD_W-1:0] sedge_grad_t;

    // position of the judged center and the end-of-frame mark
    typedef struct packed {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 frame_end;
    } sedge_meta_t;

endpackage

### rtl/core/sedge_magnitude.sv
// ----------------------------------------------------------------------------
// sedge_magnitude
// Squares both gradients, sums them and compares against the threshold
// square; holds the result in the output register.
// ----------------------------------------------------------------------------
module sedge_magnitude (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sedge_pkg::sedge_grad_t              in_gx,
    input  sedge_pkg::sedge_grad_t              in_gy,
    input  sedge_pkg::sedge_meta_t              in_meta,
    input  logic [sedge_pkg::LIM_W-1:0]         lim,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sedge_pkg::PIXEL_W-1:0]       out_edge,
    output sedge_pkg::sedge_meta_t              out_meta
);
    import sedge_pkg::*;

    logic                         sq_valid_reg;
    logic [SQ_W-1:0]              gx2_reg;
    logic [SQ_W-1:0]              gy2_reg;
    sedge_meta_t                  sq_meta_reg;
    logic                         out_valid_reg;
    logic [PIXEL_W-1:0]           out_edge_reg;
    sedge_meta_t                  out_meta_reg;

    logic signed [2*GRAD_W-1:0]   gx_prod;
    logic signed [2*GRAD_W-1:0]   gy_prod;
    logic [MAG_W-1:0]             mag;
    logic                         out_free;
    logic                         sq_ready;

    assign out_free = !out_valid_reg || out_ready;
    assign sq_ready = !sq_valid_reg || out_free;
    assign in_ready = sq_ready;

    assign gx_prod = in_gx * in_gx;
    assign gy_prod = in_gy * in_gy;
    assign mag     = {1'b0, gx2_reg} + {1'b0, gy2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (sq_ready) begin
                sq_valid_reg <= in_valid;
            end
            if (out_free) begin
                out_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_ready && in_valid) begin
            gx2_reg     <= gx_prod[SQ_W-1:0];
            gy2_reg     <= gy_prod[SQ_W-1:0];
            sq_meta_reg <= in_meta;
        end
        if (out_free && sq_valid_reg) begin
            out_edge_reg <= (LIM_W'(mag) >= lim) ? EDGE_ON : EDGE_OFF;
            out_meta_reg <= sq_meta_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_edge  = out_edge_reg;
    assign out_meta  = out_meta_reg;

endmodule

### rtl/core/sobel_edge_threshold_core.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold_core
// 3x3 Sobel edge marker over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one 8-bit grey pixel per clock in raster order while the output does
// not stall, and gives one word for each interior pixel: 255 when the squared
// Sobel magnitude is at least (edge_level + 1) squared, else 0, with the
// center column and row, tlast on the last interior pixel of a frame. Border
// pixels give no word. The line store takes one read and one write per pixel:
// it reads the two stored rows at the current column and writes them back
// when the word leaves the read-back stage. A result passes the read-back,
// gradient, square and output registers. The line store (MAX_WIDTH x 16 bits)
// needs no clearing after reset. Write sizes only while the stream is idle.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_core #(
    parameter int MAX_WIDTH = sedge_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sedge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sedge_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] pixel
    input  logic [sedge_pkg::PIXEL_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] edge_value, [18:8] center_col, [30:19] center_row, [31] zero
    output logic [sedge_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);
    import sedge_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int MW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (MW_W > SIZE_W) ? MW_W : SIZE_W;
    localparam int CX_W   = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;
    localparam int SUM_W  = PIXEL_W + 2;
    localparam logic [EW-1:0]     MAX_W_EXT = EW'(MAX_WIDTH);
    localparam logic [EW-1:0]     MIN_W     = EW'(3);
    localparam logic [SIZE_W-1:0] MIN_H     = SIZE_W'(3);

    typedef logic [2:0][PIXEL_W-1:0] sedge_col_t;

    function automatic logic [SUM_W-1:0] tap_sum(input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b,
                                                 input logic [PIXEL_W-1:0] c);
        tap_sum = SUM_W'(a) + {1'b0, b, 1'b0} + SUM_W'(c);
    endfunction

    // configuration
    logic [SIZE_W-1:0]         frame_width_reg;
    logic [SIZE_W-1:0]         frame_height_reg;
    logic [EDGE_W-1:0]         edge_level_reg;
    logic [LIM_W-1:0]          lim_reg;
    logic [SIZE_W-1:0]         edge_inc;
    logic [2*SIZE_W-1:0]       lim_prod;

    // position and line store
    logic [COL_W-1:0]          col_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [2*PIXEL_W-1:0]      row_mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0]      mem_q_reg;

    // read-back stage
    logic                      s1_valid_reg;
    logic [COL_W-1:0]          s1_addr_reg;
    logic [PIXEL_W-1:0]        s1_pixel_reg;
    logic                      s1_emit_reg;
    sedge_meta_t               s1_meta_reg;

    // gradient stage
    logic                      s2_valid_reg;
    sedge_grad_t               s2_gx_reg;
    sedge_grad_t               s2_gy_reg;
    sedge_meta_t               s2_meta_reg;

    // window: middle and newest columns, index 0 is two rows up
    sedge_col_t                win_mid_reg;
    sedge_col_t                win_new_reg;
    sedge_col_t                col_in;

    logic [EW-1:0]             w_eff;
    logic [EW-1:0]             fw_ext;
    logic [EW-1:0]             c_ext;
    logic [SIZE_W-1:0]         h_eff;
    logic                      last_col;
    logic                      last_row;
    logic                      emit;
    sedge_meta_t               meta_in;
    logic [CX_W-1:0]           col_m1;
    logic                      s_accept;
    logic                      s1_leave;
    logic                      s2_ready;
    logic                      mag_ready;
    logic [SUM_W-1:0]          sum_right;
    logic [SUM_W-1:0]          sum_left;
    logic [SUM_W-1:0]          sum_bottom;
    logic [SUM_W-1:0]          sum_top;
    logic                      out_valid;
    logic [PIXEL_W-1:0]        out_edge;
    sedge_meta_t               out_meta;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            edge_level_reg   <= EDGE_LEVEL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_EDGE_LEVEL:   edge_level_reg   <= cfg_data[EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    assign edge_inc = {1'b0, edge_level_reg} + SIZE_W'(1);
    assign lim_prod = edge_inc * edge_inc;

    always_ff @(posedge aclk) begin
        lim_reg <= lim_prod[LIM_W-1:0];
    end

    always_comb begin
        fw_ext = EW'(frame_width_reg);
        if (fw_ext < MIN_W) begin
            w_eff = MIN_W;
        end else if (fw_ext > MAX_W_EXT) begin
            w_eff = MAX_W_EXT;
        end else begin
            w_eff = fw_ext;
        end
        h_eff = (frame_height_reg < MIN_H) ? MIN_H : frame_height_reg;
    end

    // ------------------------------------------------------------- position
    assign c_ext    = EW'(col_reg);
    assign last_col = ({1'b0, c_ext} + (EW + 1)'(1)) >= {1'b0, w_eff};
    assign last_row = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, h_eff};
    assign emit     = (row_reg >= ROW_W'(2)) && (c_ext >= EW'(2))
                   && (row_reg < h_eff) && (c_ext < w_eff);
    assign col_m1   = CX_W'(col_reg) - CX_W'(1);

    always_comb begin
        meta_in.col       = col_m1[COL_OUT_W-1:0];
        meta_in.row       = row_reg - ROW_W'(1);
        meta_in.frame_end = (row_reg == h_eff - SIZE_W'(1)) && (c_ext == w_eff - EW'(1));
    end

    assign s1_leave = s1_valid_reg && (!s1_emit_reg || s2_ready);
    assign s_tready = !s1_valid_reg || s1_leave;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------ line store
    // read both rows at accept, write them back shifted when the word leaves
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem_q_reg <= row_mem[col_reg];
        end
        if (s1_leave) begin
            row_mem[s1_addr_reg] <= {mem_q_reg[PIXEL_W-1:0], s1_pixel_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg  <= col_reg;
            s1_pixel_reg <= s_tdata;
            s1_emit_reg  <= emit;
            s1_meta_reg  <= meta_in;
        end
    end

    // ------------------------------------------------------------- gradients
    assign col_in[0] = mem_q_reg[2*PIXEL_W-1:PIXEL_W];
    assign col_in[1] = mem_q_reg[PIXEL_W-1:0];
    assign col_in[2] = s1_pixel_reg;

    assign sum_right  = tap_sum(col_in[0], col_in[1], col_in[2]);
    assign sum_left   = tap_sum(win_mid_reg[0], win_mid_reg[1], win_mid_reg[2]);
    assign sum_bottom = tap_sum(win_mid_reg[2], win_new_reg[2], col_in[2]);
    assign sum_top    = tap_sum(win_mid_reg[0], win_new_reg[0], col_in[0]);

    assign s2_ready = !s2_valid_reg || mag_ready;

    always_ff @(posedge aclk) begin
        if (s1_leave) begin
            win_mid_reg <= win_new_reg;
            win_new_reg <= col_in;
        end
        if (s1_leave && s1_emit_reg) begin
            s2_gx_reg   <= $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
            s2_gy_reg   <= $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
            s2_meta_reg <= s1_meta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_leave && s1_emit_reg) begin
            s2_valid_reg <= 1'b1;
        end else if (mag_ready) begin
            s2_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------- magnitude
    sedge_magnitude u_magnitude (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .in_ready  (mag_ready),
        .in_gx     (s2_gx_reg),
        .in_gy     (s2_gy_reg),
        .in_meta   (s2_meta_reg),
        .lim       (lim_reg),
        .out_valid (out_valid),
        .out_ready (m_tready),
        .out_edge  (out_edge),
        .out_meta  (out_meta)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {1'b0, out_meta.row, out_meta.col, out_edge};
    assign m_tlast  = out_meta.frame_end;

endmodule
